// ===== src/qrs_pkg.sv =====
// Shared types, widths and codes for the quadratic root solver.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package qrs_pkg;

    // Coefficient and fixed-point formats
    localparam int CW      = 16;            // coefficient width
    localparam int FRAC    = 16;            // fraction bits of a root
    localparam int ROOT_W  = 48;            // root width, signed Q31.16
    localparam int CODE_W  = 3;

    // Derived datapath widths
    localparam int SUM_W   = CW + 2;              // a+b+c, a-b+c
    localparam int PROD_W  = 2 * CW;              // b*b, a*c
    localparam int DISC_W  = 2 * CW + 2;          // b*b - 4*a*c, signed
    localparam int RB      = CW + FRAC + 1;       // square root bits
    localparam int RAD_W   = 2 * RB;              // scaled radicand
    localparam int NUM_W   = CW + FRAC + 3;       // signed numerator
    localparam int MAG_W   = NUM_W - 1;           // numerator magnitude / quotient
    localparam int DEN_W   = CW + 2;              // signed denominator
    localparam int DMAG_W  = CW + 1;              // denominator magnitude

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef logic signed [CW-1:0]     t_coef;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [DISC_W-1:0] t_disc;
    typedef logic signed [NUM_W-1:0]  t_num;
    typedef logic signed [DEN_W-1:0]  t_den;
    typedef logic signed [ROOT_W-1:0] t_root;

    typedef enum logic [CODE_W-1:0] {
        CODE_INF   = 3'd0,
        CODE_NOLIN = 3'd1,
        CODE_LIN   = 3'd2,
        CODE_TWO   = 3'd3,
        CODE_DBL   = 3'd4,
        CODE_NONE  = 3'd5
    } t_code;

    // How the back end forms the roots
    typedef enum logic [1:0] {
        M_ZERO,     // no roots, both read zero
        M_LIN,      // root_one from the first quotient
        M_SHORT,    // root_one is +1 or -1, root_two from the second quotient
        M_QUAD      // roots from quotients around the square root, root_two only for two roots
    } t_mode;

    // One classified item
    typedef struct packed {
        t_code                  code;
        t_mode                  mode;
        logic                   plus;
        logic [DISC_W-2:0]      disc;
        t_num                   base1;
        t_num                   base2;
        t_den                   den;
    } t_task;

endpackage

`default_nettype wire

// ===== src/quadratic_root_solver.sv =====
// Path to the o_done strobe: front register, queue, radicand load, 33 square root
// digit stages, numerator and magnitude stages, 34 divider stages, output register.
// Throughput: one item per cycle while busy is low; busy rises at two queued items.
// Reset: synchronous, active low; clears all valid bits and the queue, drops items.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Top level: joins qrs_front, qrs_queue and qrs_back; depends on qrs_pkg.
`default_nettype none

module quadratic_root_solver (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [qrs_pkg::CW-1:0] i_coef_a,
    input  wire logic signed [qrs_pkg::CW-1:0] i_coef_b,
    input  wire logic signed [qrs_pkg::CW-1:0] i_coef_c,
    output logic                               o_done,
    output logic [qrs_pkg::CODE_W-1:0]         o_case_code,
    output logic signed [qrs_pkg::ROOT_W-1:0]  o_root_one,
    output logic signed [qrs_pkg::ROOT_W-1:0]  o_root_two
);

    logic           accept;
    logic           push, pop;
    qrs_pkg::t_task push_task, pop_task;

    assign accept = start && !busy;

    // Classify items
    qrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_coef_a (i_coef_a),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .o_push   (push),
        .o_task   (push_task)
    );

    // Buffer items between the two ends
    qrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (push_task),
        .o_pop   (pop),
        .o_task  (pop_task),
        .o_busy  (busy)
    );

    // Compute roots
    qrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (pop),
        .i_task      (pop_task),
        .o_done      (o_done),
        .o_case_code (o_case_code),
        .o_root_one  (o_root_one),
        .o_root_two  (o_root_two)
    );

endmodule

`default_nettype wire

// ===== src/qrs_front.sv =====
// Front end: registers products and sums of the coefficients, then classifies.
// Depends on qrs_pkg.
`default_nettype none

module qrs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire qrs_pkg::t_coef i_coef_a,
    input  wire qrs_pkg::t_coef i_coef_b,
    input  wire qrs_pkg::t_coef i_coef_c,
    output logic               o_push,
    output qrs_pkg::t_task     o_task
);

    logic           r_v;
    qrs_pkg::t_coef r_a, r_b, r_c;
    qrs_pkg::t_prod r_bb, r_ac;
    qrs_pkg::t_sum  r_sp, r_sm;

    qrs_pkg::t_disc disc;
    qrs_pkg::t_num  c_sc;
    qrs_pkg::t_num  b_sc;
    qrs_pkg::t_task n_task;

    // Hold the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_accept;
        end
    end

    // Capture coefficients, products and check sums
    always_ff @(posedge i_clk) begin
        r_a  <= i_coef_a;
        r_b  <= i_coef_b;
        r_c  <= i_coef_c;
        r_bb <= qrs_pkg::t_prod'(i_coef_b) * qrs_pkg::t_prod'(i_coef_b);
        r_ac <= qrs_pkg::t_prod'(i_coef_a) * qrs_pkg::t_prod'(i_coef_c);
        r_sp <= qrs_pkg::t_sum'(i_coef_a) + qrs_pkg::t_sum'(i_coef_b)
              + qrs_pkg::t_sum'(i_coef_c);
        r_sm <= qrs_pkg::t_sum'(i_coef_a) - qrs_pkg::t_sum'(i_coef_b)
              + qrs_pkg::t_sum'(i_coef_c);
    end

    // Classify the item and set up numerators and denominator
    always_comb begin
        disc = qrs_pkg::t_disc'(r_bb) - (qrs_pkg::t_disc'(r_ac) <<< 2);
        c_sc = qrs_pkg::t_num'(r_c) <<< qrs_pkg::FRAC;
        b_sc = qrs_pkg::t_num'(r_b) <<< qrs_pkg::FRAC;

        n_task       = '0;
        n_task.code  = qrs_pkg::CODE_INF;
        n_task.mode  = qrs_pkg::M_ZERO;
        n_task.den   = qrs_pkg::t_den'(1);

        if (r_a == '0) begin
            if (r_b == '0) begin
                n_task.code = (r_c == '0) ? qrs_pkg::CODE_INF : qrs_pkg::CODE_NOLIN;
            end else begin
                n_task.code  = qrs_pkg::CODE_LIN;
                n_task.mode  = qrs_pkg::M_LIN;
                n_task.base1 = -c_sc;
                n_task.den   = qrs_pkg::t_den'(r_b);
            end
        end else if (r_sp == '0 || r_sm == '0) begin
            n_task.code  = qrs_pkg::CODE_TWO;
            n_task.mode  = qrs_pkg::M_SHORT;
            n_task.plus  = (r_sp == '0);
            n_task.base2 = (r_sp == '0) ? c_sc : -c_sc;
            n_task.den   = qrs_pkg::t_den'(r_a);
        end else if (disc[qrs_pkg::DISC_W-1]) begin
            n_task.code = qrs_pkg::CODE_NONE;
        end else begin
            n_task.code  = (disc == '0) ? qrs_pkg::CODE_DBL : qrs_pkg::CODE_TWO;
            n_task.mode  = qrs_pkg::M_QUAD;
            n_task.disc  = disc[qrs_pkg::DISC_W-2:0];
            n_task.base1 = -b_sc;
            n_task.base2 = -b_sc;
            n_task.den   = qrs_pkg::t_den'(r_a) <<< 1;
        end
    end

    assign o_push = r_v;
    assign o_task = n_task;

endmodule

`default_nettype wire

// ===== src/qrs_queue.sv =====
// Short item queue between front and back ends; the back end drains one a cycle.
// Depends on qrs_pkg.
`default_nettype none

module qrs_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire qrs_pkg::t_task i_task,
    output logic                o_pop,
    output qrs_pkg::t_task      o_task,
    output logic                o_busy
);

    qrs_pkg::t_task                r_mem [0:qrs_pkg::Q_DEPTH-1];
    logic [qrs_pkg::Q_AW-1:0]      r_wp, r_rp;
    logic [qrs_pkg::Q_AW:0]        r_cnt;
    logic [qrs_pkg::Q_AW:0]        n_cnt;
    logic                          pop;

    assign pop   = (r_cnt != '0);
    assign n_cnt = r_cnt + (qrs_pkg::Q_AW+1)'(i_push) - (qrs_pkg::Q_AW+1)'(pop);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    // Store items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_task;
        end
    end

    assign o_pop  = pop;
    assign o_task = r_mem[r_rp];
    // Leave room for the item still in the front register
    assign o_busy = (r_cnt >= (qrs_pkg::Q_AW+1)'(qrs_pkg::Q_DEPTH - 2));

endmodule

`default_nettype wire

// ===== src/qrs_back.sv =====
// Back end: pipelined square root, two pipelined dividers and root selection.
// Depends on qrs_pkg.
`default_nettype none

module qrs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire qrs_pkg::t_task i_task,
    output logic                o_done,
    output logic [qrs_pkg::CODE_W-1:0] o_case_code,
    output qrs_pkg::t_root      o_root_one,
    output qrs_pkg::t_root      o_root_two
);

    localparam int RB  = qrs_pkg::RB;
    localparam int MW  = qrs_pkg::MAG_W;
    localparam int DMW = qrs_pkg::DMAG_W;

    // ---------------- square root stages ----------------
    logic                       r_sq_v    [0:RB];
    qrs_pkg::t_task             r_sq_tk   [0:RB];
    logic [qrs_pkg::RAD_W-1:0]  r_sq_rad  [0:RB];
    logic [RB+1:0]              r_sq_rem  [0:RB];
    logic [RB-1:0]              r_sq_root [0:RB];

    // Load the scaled radicand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_tk[0]   <= i_task;
        r_sq_rad[0]  <= qrs_pkg::RAD_W'(i_task.disc) << (2 * qrs_pkg::FRAC);
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
    end

    // One root digit per stage
    for (genvar k = 0; k < RB; k++) begin : g_sq
        logic [RB+1:0] rem_sh, trial;
        logic          ge;

        assign rem_sh = {r_sq_rem[k][RB-1:0], r_sq_rad[k][qrs_pkg::RAD_W-1 -: 2]};
        assign trial  = {r_sq_root[k], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_tk[k+1]   <= r_sq_tk[k];
            r_sq_rad[k+1]  <= r_sq_rad[k] << 2;
            r_sq_rem[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
            r_sq_root[k+1] <= {r_sq_root[k][RB-2:0], ge};
        end
    end

    // ---------------- numerator forming ----------------
    logic           r_ad_v;
    qrs_pkg::t_task r_ad_tk;
    qrs_pkg::t_num  r_ad_n1, r_ad_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ad_v <= 1'b0;
        end else begin
            r_ad_v <= r_sq_v[RB];
        end
    end

    // Add the root to base1, subtract it from base2; both bases are -b for M_QUAD
    always_ff @(posedge i_clk) begin
        r_ad_tk <= r_sq_tk[RB];
        r_ad_n1 <= r_sq_tk[RB].base1 + qrs_pkg::t_num'(r_sq_root[RB]);
        r_ad_n2 <= r_sq_tk[RB].base2 - qrs_pkg::t_num'(r_sq_root[RB]);
    end

    // ---------------- division stages ----------------
    logic            r_dv_v   [0:MW];
    qrs_pkg::t_task  r_dv_tk  [0:MW];
    logic [DMW-1:0]  r_dv_d   [0:MW];
    logic [1:0]      r_dv_neg [0:MW];
    logic [MW-1:0]   r_dv_n1  [0:MW];
    logic [MW-1:0]   r_dv_n2  [0:MW];
    logic [DMW-1:0]  r_dv_r1  [0:MW];
    logic [DMW-1:0]  r_dv_r2  [0:MW];
    logic [MW-1:0]   r_dv_q1  [0:MW];
    logic [MW-1:0]   r_dv_q2  [0:MW];

    qrs_pkg::t_num   abs1, abs2;
    qrs_pkg::t_den   dabs;
    logic            dneg;

    always_comb begin
        dneg = r_ad_tk.den[qrs_pkg::DEN_W-1];
        abs1 = r_ad_n1[qrs_pkg::NUM_W-1] ? -r_ad_n1 : r_ad_n1;
        abs2 = r_ad_n2[qrs_pkg::NUM_W-1] ? -r_ad_n2 : r_ad_n2;
        dabs = dneg ? -r_ad_tk.den : r_ad_tk.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_ad_v;
        end
    end

    // Take magnitudes and quotient signs
    always_ff @(posedge i_clk) begin
        r_dv_tk[0]  <= r_ad_tk;
        r_dv_d[0]   <= dabs[DMW-1:0];
        r_dv_neg[0] <= {r_ad_n2[qrs_pkg::NUM_W-1] ^ dneg, r_ad_n1[qrs_pkg::NUM_W-1] ^ dneg};
        r_dv_n1[0]  <= abs1[MW-1:0];
        r_dv_n2[0]  <= abs2[MW-1:0];
        r_dv_r1[0]  <= '0;
        r_dv_r2[0]  <= '0;
        r_dv_q1[0]  <= '0;
        r_dv_q2[0]  <= '0;
    end

    // One quotient bit per stage in each lane
    for (genvar k = 0; k < MW; k++) begin : g_dv
        logic [DMW:0] sh1, sh2;
        logic         ge1, ge2;

        assign sh1 = {r_dv_r1[k], r_dv_n1[k][MW-1]};
        assign sh2 = {r_dv_r2[k], r_dv_n2[k][MW-1]};
        assign ge1 = (sh1 >= {1'b0, r_dv_d[k]});
        assign ge2 = (sh2 >= {1'b0, r_dv_d[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_tk[k+1]  <= r_dv_tk[k];
            r_dv_d[k+1]   <= r_dv_d[k];
            r_dv_neg[k+1] <= r_dv_neg[k];
            r_dv_n1[k+1]  <= r_dv_n1[k] << 1;
            r_dv_n2[k+1]  <= r_dv_n2[k] << 1;
            r_dv_r1[k+1]  <= ge1 ? DMW'(sh1 - {1'b0, r_dv_d[k]}) : sh1[DMW-1:0];
            r_dv_r2[k+1]  <= ge2 ? DMW'(sh2 - {1'b0, r_dv_d[k]}) : sh2[DMW-1:0];
            r_dv_q1[k+1]  <= {r_dv_q1[k][MW-2:0], ge1};
            r_dv_q2[k+1]  <= {r_dv_q2[k][MW-2:0], ge2};
        end
    end

    // ---------------- root selection ----------------
    qrs_pkg::t_task  ftk;
    qrs_pkg::t_num   qs1, qs2;
    qrs_pkg::t_root  q1r, q2r, one_fx, first;
    qrs_pkg::t_code  n_code;
    qrs_pkg::t_root  n_r1, n_r2;

    always_comb begin
        ftk    = r_dv_tk[MW];
        qs1    = r_dv_neg[MW][0] ? -qrs_pkg::t_num'(r_dv_q1[MW]) : qrs_pkg::t_num'(r_dv_q1[MW]);
        qs2    = r_dv_neg[MW][1] ? -qrs_pkg::t_num'(r_dv_q2[MW]) : qrs_pkg::t_num'(r_dv_q2[MW]);
        q1r    = qrs_pkg::t_root'(qs1);
        q2r    = qrs_pkg::t_root'(qs2);
        one_fx = qrs_pkg::t_root'(1) <<< qrs_pkg::FRAC;
        first  = ftk.plus ? one_fx : -one_fx;

        n_code = ftk.code;
        n_r1   = '0;
        n_r2   = '0;
        case (ftk.mode)
            qrs_pkg::M_LIN: begin
                n_r1 = q1r;
            end
            qrs_pkg::M_SHORT: begin
                n_r1 = first;
                if (q2r == first) begin
                    n_code = qrs_pkg::CODE_DBL;
                end else begin
                    n_r2 = q2r;
                end
            end
            qrs_pkg::M_QUAD: begin
                n_r1 = q1r;
                if (ftk.code == qrs_pkg::CODE_TWO) begin
                    n_r2 = q2r;
                end
            end
            default: begin
                n_r1 = '0;
            end
        endcase
    end

    // Hold the result for its one strobe cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_dv_v[MW];
        end
    end

    always_ff @(posedge i_clk) begin
        o_case_code <= n_code;
        o_root_one  <= n_r1;
        o_root_two  <= n_r2;
    end

endmodule

`default_nettype wire

// ===== src/qrs_checker.sv =====
// Port-level checks on results of the quadratic root solver, bound to the top level.
// Depends on qrs_pkg.
`default_nettype none

module qrs_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic signed [qrs_pkg::CW-1:0] i_coef_a,
    input  wire logic signed [qrs_pkg::CW-1:0] i_coef_b,
    input  wire logic signed [qrs_pkg::CW-1:0] i_coef_c,
    input  wire logic                          o_done,
    input  wire logic [qrs_pkg::CODE_W-1:0]    o_case_code,
    input  wire logic signed [qrs_pkg::ROOT_W-1:0] o_root_one,
    input  wire logic signed [qrs_pkg::ROOT_W-1:0] o_root_two
);

    // Drop results in flight on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

    // Keep codes in range
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_case_code <= qrs_pkg::CODE_NONE))
        else $error("case code out of range");

    // Zero both roots when there is no root
    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_case_code == qrs_pkg::CODE_INF || o_case_code == qrs_pkg::CODE_NOLIN
                   || o_case_code == qrs_pkg::CODE_NONE)
        |-> (o_root_one == '0 && o_root_two == '0))
        else $error("root given where none exists");

    // Zero the second root unless there are two
    a_second_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_case_code != qrs_pkg::CODE_TWO) |-> (o_root_two == '0))
        else $error("second root given for a single root case");

    // Unused inputs in these checks
    logic unused;
    assign unused = start ^ busy ^ (^i_coef_a) ^ (^i_coef_b) ^ (^i_coef_c);

endmodule

bind quadratic_root_solver qrs_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_coef_a    (i_coef_a),
    .i_coef_b    (i_coef_b),
    .i_coef_c    (i_coef_c),
    .o_done      (o_done),
    .o_case_code (o_case_code),
    .o_root_one  (o_root_one),
    .o_root_two  (o_root_two)
);

`default_nettype wire
